// ===== src/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Shared widths, constants and types of the sphere collision time block.
// ----------------------------------------------------------------------------
package scs_pkg;

   // port field widths
   localparam int FIELD_BITS     = 63;
   localparam int RADIUS_IN_BITS = 20;

   // coordinate format, signed Q10.10 components packed from bit 0
   localparam int COORD_BITS  = 21;
   localparam int RADIUS_BITS = COORD_BITS - 1;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int RS_BITS     = RADIUS_BITS + 1;
   localparam int RR_BITS     = 2 * RS_BITS;

   // quadratic coefficients
   localparam int A_BITS   = PROD_BITS;
   localparam int B_BITS   = PROD_BITS + 1;
   localparam int MAG_BITS = PROD_BITS;
   localparam int LO_BITS  = MAG_BITS / 2;
   localparam int HI_BITS  = MAG_BITS - LO_BITS;
   localparam int PP_BITS  = 2 * HI_BITS;
   localparam int SQ_BITS  = 2 * MAG_BITS;
   localparam int D_BITS   = SQ_BITS + 1;

   // square root of the discriminant scaled by the time fraction
   localparam int FRAC_BITS = 16;
   localparam int NRAW_BITS = D_BITS + 2 * FRAC_BITS;
   localparam int N_BITS    = NRAW_BITS + (NRAW_BITS % 2);
   localparam int ROOT_BITS = N_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 4;

   // numerator and time
   localparam int TIME_BITS = 32;
   localparam int M_BITS    = ((B_BITS + FRAC_BITS > ROOT_BITS) ?
                               (B_BITS + FRAC_BITS) : ROOT_BITS) + 2;
   localparam int MU_BITS   = M_BITS - 1;
   localparam int CMP_BITS  = (A_BITS + TIME_BITS > MU_BITS) ?
                              (A_BITS + TIME_BITS) : MU_BITS;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   // coefficient word handed from front to back
   typedef struct packed {
      logic [A_BITS-1:0]        a;
      logic signed [B_BITS-1:0] b;
      logic signed [B_BITS-1:0] c;
   } scs_item_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } scs_qstat_type;

endpackage

// ===== src/scs_if.sv =====
// ----------------------------------------------------------------------------
// scs_req_if / scs_rsp_if
// Valid/ready channels carrying sphere pairs in and contact results out.
// ----------------------------------------------------------------------------
interface scs_req_if import scs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FIELD_BITS-1:0]     pos_first;
   logic [FIELD_BITS-1:0]     pos_second;
   logic [FIELD_BITS-1:0]     vel_first;
   logic [FIELD_BITS-1:0]     vel_second;
   logic [RADIUS_IN_BITS-1:0] radius_first;
   logic [RADIUS_IN_BITS-1:0] radius_second;

   modport source (output valid, pos_first, pos_second, vel_first, vel_second,
                   radius_first, radius_second, input ready);
   modport sink   (input valid, pos_first, pos_second, vel_first, vel_second,
                   radius_first, radius_second, output ready);
endinterface

interface scs_rsp_if import scs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [TIME_BITS-1:0] contact_time;

   modport source (output valid, hit, contact_time, input ready);
   modport sink   (input valid, hit, contact_time, output ready);
endinterface

// ===== src/scs_front.sv =====
// ----------------------------------------------------------------------------
// scs_front
// Unpacks a sphere pair and forms the coefficients a, b and c in three stages.
// ----------------------------------------------------------------------------
module scs_front import scs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   scs_req_if.sink       req,
   input  scs_qstat_type qstat,
   output logic          push,
   output scs_item_type  item
);

   logic adv;
   logic f1_vld_ff, f2_vld_ff, f3_vld_ff;

   logic signed [DIFF_BITS-1:0] xs_ff [3];
   logic signed [DIFF_BITS-1:0] xs_in [3];
   logic signed [DIFF_BITS-1:0] vs_ff [3];
   logic signed [DIFF_BITS-1:0] vs_in [3];
   logic [RS_BITS-1:0]          rs_ff, rs_in;

   logic signed [PROD_BITS-1:0] vv_ff [3];
   logic signed [PROD_BITS-1:0] vv_in [3];
   logic signed [PROD_BITS-1:0] xv_ff [3];
   logic signed [PROD_BITS-1:0] xv_in [3];
   logic signed [PROD_BITS-1:0] xx_ff [3];
   logic signed [PROD_BITS-1:0] xx_in [3];
   logic [RR_BITS-1:0]          rr_ff, rr_in;

   scs_item_type item_ff, item_in;

   // stall only when the last stage holds a word the queue cannot take
   assign adv       = !(f3_vld_ff && qstat.full);
   assign req.ready = adv;
   assign push      = f3_vld_ff && !qstat.full;
   assign item      = item_ff;

   // relative position, relative velocity, radius sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xs_in[i] = DIFF_BITS'($signed(req.pos_first[i*COORD_BITS +: COORD_BITS]))
                  - DIFF_BITS'($signed(req.pos_second[i*COORD_BITS +: COORD_BITS]));
         vs_in[i] = DIFF_BITS'($signed(req.vel_first[i*COORD_BITS +: COORD_BITS]))
                  - DIFF_BITS'($signed(req.vel_second[i*COORD_BITS +: COORD_BITS]));
      end
      rs_in = RS_BITS'(req.radius_first[RADIUS_BITS-1:0])
            + RS_BITS'(req.radius_second[RADIUS_BITS-1:0]);
   end

   // component products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vv_in[i] = PROD_BITS'(vs_ff[i] * vs_ff[i]);
         xv_in[i] = PROD_BITS'(xs_ff[i] * vs_ff[i]);
         xx_in[i] = PROD_BITS'(xs_ff[i] * xs_ff[i]);
      end
      rr_in = RR_BITS'(rs_ff * rs_ff);
   end

   // dot products and c
   always_comb begin
      item_in.a = A_BITS'(vv_ff[0]) + A_BITS'(vv_ff[1]) + A_BITS'(vv_ff[2]);
      item_in.b = B_BITS'(xv_ff[0]) + B_BITS'(xv_ff[1]) + B_BITS'(xv_ff[2]);
      item_in.c = B_BITS'(xx_ff[0]) + B_BITS'(xx_ff[1]) + B_BITS'(xx_ff[2])
                - B_BITS'(rr_ff);
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= req.valid;
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            xs_ff[i] <= xs_in[i];
            vs_ff[i] <= vs_in[i];
            vv_ff[i] <= vv_in[i];
            xv_ff[i] <= xv_in[i];
            xx_ff[i] <= xx_in[i];
         end
         rs_ff   <= rs_in;
         rr_ff   <= rr_in;
         item_ff <= item_in;
      end
   end

endmodule

// ===== src/scs_queue.sv =====
// ----------------------------------------------------------------------------
// scs_queue
// Short first-in first-out queue of coefficient words between front and back.
// ----------------------------------------------------------------------------
module scs_queue import scs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  scs_item_type  push_item,
   input  logic          pop,
   output scs_item_type  pop_item,
   output scs_qstat_type qstat
);

   scs_item_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_item    = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

endmodule

// ===== src/scs_back.sv =====
// ----------------------------------------------------------------------------
// scs_back
// Discriminant, pipelined square root, root selection and pipelined divide.
// ----------------------------------------------------------------------------
module scs_back import scs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  scs_item_type  pop_item,
   input  scs_qstat_type qstat,
   output logic          pop,
   scs_rsp_if.source     rsp
);

   typedef struct packed {
      logic [A_BITS-1:0]        a;
      logic signed [B_BITS-1:0] b;
      logic                     c_neg;
      logic                     c_zero;
      logic [PP_BITS-1:0]       bb_hh;
      logic [PP_BITS-1:0]       bb_hl;
      logic [PP_BITS-1:0]       bb_ll;
      logic [PP_BITS-1:0]       ac_hh;
      logic [PP_BITS-1:0]       ac_hl;
      logic [PP_BITS-1:0]       ac_lh;
      logic [PP_BITS-1:0]       ac_ll;
   } scs_pp_type;

   typedef struct packed {
      logic [A_BITS-1:0]        a;
      logic signed [B_BITS-1:0] b;
      logic                     c_neg;
      logic                     c_zero;
      logic [SQ_BITS-1:0]       b2;
      logic [SQ_BITS-1:0]       ac;
   } scs_sq_type;

   typedef struct packed {
      logic [N_BITS-1:0]        rad;
      logic [REM_BITS-1:0]      rem;
      logic [ROOT_BITS-1:0]     root;
      logic [A_BITS-1:0]        a;
      logic signed [B_BITS-1:0] b;
      logic                     lower_root;
      logic                     nohit;
   } scs_root_type;

   typedef struct packed {
      logic [A_BITS-1:0]        a;
      logic signed [M_BITS-1:0] m;
      logic                     nohit;
   } scs_m_type;

   typedef struct packed {
      logic [A_BITS-1:0]    rem;
      logic [TIME_BITS-1:0] lq;
      logic [A_BITS-1:0]    a;
      logic                 sat;
      logic                 nohit;
   } scs_div_type;

   typedef struct packed {
      logic                 hit;
      logic [TIME_BITS-1:0] contact_time;
   } scs_out_type;

   logic adv;

   logic         s0_vld_ff, s1_vld_ff, s2_vld_ff, m_vld_ff, out_vld_ff;
   scs_item_type s0_ff;
   scs_pp_type   s1_ff, s1_in;
   scs_sq_type   s2_ff, s2_in;
   scs_m_type    m_ff, m_in;
   scs_out_type  out_ff, out_in;

   logic         root_vld_ff [ROOT_BITS+1];
   scs_root_type root_ff     [ROOT_BITS+1];
   scs_root_type root_in     [ROOT_BITS+1];
   logic         div_vld_ff  [TIME_BITS+1];
   scs_div_type  div_ff      [TIME_BITS+1];
   scs_div_type  div_in      [TIME_BITS+1];

   logic [MAG_BITS-1:0] b_mag, c_mag;
   logic [D_BITS-1:0]   d_val;
   logic                b_pos, d_ge;
   logic [MU_BITS-1:0]  m_clamp;

   // whole back end moves when the output register is free or being taken
   assign adv              = !out_vld_ff || rsp.ready;
   assign pop              = adv && !qstat.empty;
   assign rsp.valid        = out_vld_ff;
   assign rsp.hit          = out_ff.hit;
   assign rsp.contact_time = out_ff.contact_time;

   // magnitudes split into halves for partial products
   always_comb begin
      b_mag = s0_ff.b[B_BITS-1] ? MAG_BITS'(-s0_ff.b) : MAG_BITS'(s0_ff.b);
      c_mag = s0_ff.c[B_BITS-1] ? MAG_BITS'(-s0_ff.c) : MAG_BITS'(s0_ff.c);
      s1_in.a      = s0_ff.a;
      s1_in.b      = s0_ff.b;
      s1_in.c_neg  = s0_ff.c[B_BITS-1];
      s1_in.c_zero = (s0_ff.c == '0);
      s1_in.bb_hh  = PP_BITS'(b_mag[MAG_BITS-1:LO_BITS] * b_mag[MAG_BITS-1:LO_BITS]);
      s1_in.bb_hl  = PP_BITS'(b_mag[MAG_BITS-1:LO_BITS] * b_mag[LO_BITS-1:0]);
      s1_in.bb_ll  = PP_BITS'(b_mag[LO_BITS-1:0] * b_mag[LO_BITS-1:0]);
      s1_in.ac_hh  = PP_BITS'(s0_ff.a[MAG_BITS-1:LO_BITS] * c_mag[MAG_BITS-1:LO_BITS]);
      s1_in.ac_hl  = PP_BITS'(s0_ff.a[MAG_BITS-1:LO_BITS] * c_mag[LO_BITS-1:0]);
      s1_in.ac_lh  = PP_BITS'(s0_ff.a[LO_BITS-1:0] * c_mag[MAG_BITS-1:LO_BITS]);
      s1_in.ac_ll  = PP_BITS'(s0_ff.a[LO_BITS-1:0] * c_mag[LO_BITS-1:0]);
   end

   // partial product sums: b*b and a*|c|
   always_comb begin
      s2_in.a      = s1_ff.a;
      s2_in.b      = s1_ff.b;
      s2_in.c_neg  = s1_ff.c_neg;
      s2_in.c_zero = s1_ff.c_zero;
      s2_in.b2     = (SQ_BITS'(s1_ff.bb_hh) << (2 * LO_BITS))
                   + (SQ_BITS'(s1_ff.bb_hl) << (LO_BITS + 1))
                   + SQ_BITS'(s1_ff.bb_ll);
      s2_in.ac     = (SQ_BITS'(s1_ff.ac_hh) << (2 * LO_BITS))
                   + ((SQ_BITS'(s1_ff.ac_hl) + SQ_BITS'(s1_ff.ac_lh)) << LO_BITS)
                   + SQ_BITS'(s1_ff.ac_ll);
   end

   // discriminant and root class
   always_comb begin
      d_ge  = (s2_ff.b2 >= s2_ff.ac);
      d_val = s2_ff.c_neg ? D_BITS'(s2_ff.b2) + D_BITS'(s2_ff.ac)
                          : D_BITS'(s2_ff.b2) - D_BITS'(s2_ff.ac);
      b_pos = !s2_ff.b[B_BITS-1] && (s2_ff.b != '0);
      root_in[0].rad        = N_BITS'(d_val) << (2 * FRAC_BITS);
      root_in[0].rem        = '0;
      root_in[0].root       = '0;
      root_in[0].a          = s2_ff.a;
      root_in[0].b          = s2_ff.b;
      root_in[0].lower_root = !b_pos && !s2_ff.c_neg;
      root_in[0].nohit      = (s2_ff.a == '0) || (!s2_ff.c_neg && !d_ge)
                            || (b_pos && !s2_ff.c_neg && !s2_ff.c_zero);
   end

   // square root, one result bit per stage
   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
      logic [REM_BITS-1:0] rem_sh;
      logic [REM_BITS-1:0] trial;

      always_comb begin
         rem_sh = {root_ff[i].rem[REM_BITS-3:0], root_ff[i].rad[N_BITS-1 -: 2]};
         trial  = REM_BITS'({root_ff[i].root, 2'b01});
         root_in[i+1]     = root_ff[i];
         root_in[i+1].rad = root_ff[i].rad << 2;
         if (rem_sh >= trial) begin
            root_in[i+1].rem  = rem_sh - trial;
            root_in[i+1].root = {root_ff[i].root[ROOT_BITS-2:0], 1'b1};
         end else begin
            root_in[i+1].rem  = rem_sh;
            root_in[i+1].root = {root_ff[i].root[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   // numerator of the chosen root
   always_comb begin
      m_in.a     = root_ff[ROOT_BITS].a;
      m_in.nohit = root_ff[ROOT_BITS].nohit;
      if (root_ff[ROOT_BITS].lower_root) begin
         m_in.m = ((-M_BITS'(root_ff[ROOT_BITS].b)) <<< FRAC_BITS)
                - M_BITS'(root_ff[ROOT_BITS].root)
                - M_BITS'(root_ff[ROOT_BITS].rem != '0);
      end else begin
         m_in.m = ((-M_BITS'(root_ff[ROOT_BITS].b)) <<< FRAC_BITS)
                + M_BITS'(root_ff[ROOT_BITS].root);
      end
   end

   // clamp at zero, saturation check, divider seed
   always_comb begin
      m_clamp         = m_ff.m[M_BITS-1] ? '0 : m_ff.m[MU_BITS-1:0];
      div_in[0].a     = m_ff.a;
      div_in[0].nohit = m_ff.nohit;
      div_in[0].sat   = CMP_BITS'(m_clamp) >= (CMP_BITS'(m_ff.a) << TIME_BITS);
      div_in[0].rem   = A_BITS'(m_clamp >> TIME_BITS);
      div_in[0].lq    = m_clamp[TIME_BITS-1:0];
   end

   // restoring divide, one quotient bit per stage
   for (genvar i = 0; i < TIME_BITS; i++) begin : g_div
      logic [A_BITS:0] rem_sh;
      logic            ge;

      always_comb begin
         rem_sh = {div_ff[i].rem, div_ff[i].lq[TIME_BITS-1]};
         ge     = (rem_sh >= (A_BITS+1)'(div_ff[i].a));
         div_in[i+1]     = div_ff[i];
         div_in[i+1].rem = ge ? A_BITS'(rem_sh - (A_BITS+1)'(div_ff[i].a))
                              : rem_sh[A_BITS-1:0];
         div_in[i+1].lq  = {div_ff[i].lq[TIME_BITS-2:0], ge};
      end
   end

   // result word
   always_comb begin
      out_in.hit = !div_ff[TIME_BITS].nohit;
      if (div_ff[TIME_BITS].nohit) begin
         out_in.contact_time = '0;
      end else if (div_ff[TIME_BITS].sat) begin
         out_in.contact_time = '1;
      end else begin
         out_in.contact_time = div_ff[TIME_BITS].lq;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         m_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i <= ROOT_BITS; i++) begin
            root_vld_ff[i] <= 1'b0;
         end
         for (int i = 0; i <= TIME_BITS; i++) begin
            div_vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         s0_vld_ff      <= pop;
         s1_vld_ff      <= s0_vld_ff;
         s2_vld_ff      <= s1_vld_ff;
         root_vld_ff[0] <= s2_vld_ff;
         for (int i = 0; i < ROOT_BITS; i++) begin
            root_vld_ff[i+1] <= root_vld_ff[i];
         end
         m_vld_ff      <= root_vld_ff[ROOT_BITS];
         div_vld_ff[0] <= m_vld_ff;
         for (int i = 0; i < TIME_BITS; i++) begin
            div_vld_ff[i+1] <= div_vld_ff[i];
         end
         out_vld_ff <= div_vld_ff[TIME_BITS];
      end
   end

   // payload chain
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= pop_item;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         for (int i = 0; i <= ROOT_BITS; i++) begin
            root_ff[i] <= root_in[i];
         end
         m_ff <= m_in;
         for (int i = 0; i <= TIME_BITS; i++) begin
            div_ff[i] <= div_in[i];
         end
         out_ff <= out_in;
      end
   end

   a_miss_zero_time: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_ff.hit) |-> (out_ff.contact_time == '0))
      else $error("miss reported with nonzero time");
   a_root_remainder: assert property (@(posedge clock) disable iff (reset)
      root_vld_ff[ROOT_BITS] |->
         (root_ff[ROOT_BITS].rem <= REM_BITS'({root_ff[ROOT_BITS].root, 1'b0})))
      else $error("square root remainder out of range");
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (div_vld_ff[TIME_BITS] && !div_ff[TIME_BITS].nohit && !div_ff[TIME_BITS].sat)
         |-> (div_ff[TIME_BITS].rem < div_ff[TIME_BITS].a))
      else $error("divider remainder not below divisor");

endmodule

// ===== src/sphere_collision_time.sv =====
// ----------------------------------------------------------------------------
// sphere_collision_time
// Earliest contact time of two spheres moving on straight lines.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one sphere pair per word: packed Q10.10 positions and
//   velocities and two Q10.10 radii. rsp returns one word per pair, in
//   order: hit and the contact time in unsigned Q16.16, saturated, zero on
//   a miss. Both channels transfer a word when valid and ready are high.
//   Throughput is one pair per cycle while rsp is not stalled. A word
//   passes 104 registers: 3 front stages, the queue, 4 discriminant
//   stages, 61 square root stages (one root bit each), 2 root selection
//   stages, 32 divide stages (one quotient bit each) and the output
//   register.
//   When rsp is stalled the back end holds; the front end keeps taking pairs
//   until the 4-word queue and its own 3 stages are full, then drops ready.
//   Synchronous reset empties the pipeline and the queue; no results are
//   pending after reset and req.ready is high.
// ----------------------------------------------------------------------------
module sphere_collision_time import scs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   scs_req_if.sink   req,
   scs_rsp_if.source rsp
);

   logic          push;
   logic          pop;
   scs_item_type  push_item;
   scs_item_type  pop_item;
   scs_qstat_type qstat;

   // coefficient formation
   scs_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .qstat (qstat),
      .push  (push),
      .item  (push_item)
   );

   // decoupling queue
   scs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   // root and time computation
   scs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_item (pop_item),
      .qstat    (qstat),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

// ===== sim/sphere_collision_time_test.sv =====
// ----------------------------------------------------------------------------
// sphere_collision_time_test
// Drives sphere pairs into the collision time block, predicts each contact
// result with a wide integer model of the quadratic and checks it in order.
// ----------------------------------------------------------------------------
module sphere_collision_time_test;
   import scs_pkg::*;

   typedef struct {
      logic        hit;
      logic [31:0] contact_time;
   } contact_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scs_req_if req ();
   scs_rsp_if rsp ();

   sphere_collision_time i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   contact_type expected_contacts[$];
   int          mismatch_count = 0;
   int          idle_percent   = 17;
   int          quiet_cycles   = 0;
   logic        stimulus_done  = 1'b0;

   always #5 clock = ~clock;

   // signed component of a packed vector
   function automatic longint coord(logic [62:0] packed_vec, int idx);
      logic signed [20:0] raw;
      begin
         raw = packed_vec[idx*21 +: 21];
         return longint'(raw);
      end
   endfunction

   // floor square root of a wide unsigned value
   function automatic logic [127:0] root_floor(logic [255:0] n);
      logic [127:0] root;
      logic [127:0] cand;
      begin
         root = '0;
         for (int k = 127; k >= 0; k--) begin
            cand = root | (128'd1 << k);
            if ((256'(cand) * 256'(cand)) <= n) root = cand;
         end
         return root;
      end
   endfunction

   // contact time of one sphere pair
   function automatic contact_type predict_contact(logic [62:0] p1, logic [62:0] p2,
                                                   logic [62:0] v1, logic [62:0] v2,
                                                   logic [19:0] r1, logic [19:0] r2);
      contact_type       res;
      longint            xd, vd, b, xx, rs, c;
      longint unsigned   a;
      logic signed [255:0] d, m, sq, bw;
      logic        [255:0] n, q;
      begin
         res.hit = 1'b0;
         res.contact_time = '0;
         a = 0; b = 0; xx = 0;
         for (int i = 0; i < 3; i++) begin
            xd = coord(p1, i) - coord(p2, i);
            vd = coord(v1, i) - coord(v2, i);
            a  += longint'(vd * vd);
            b  += xd * vd;
            xx += xd * xd;
         end
         rs = longint'(r1) + longint'(r2);
         c  = xx - rs * rs;
         if (a == 0) return res;
         bw = 256'(signed'(b));
         d  = bw * bw - 256'(a) * 256'(signed'(c));
         if (d < 0) return res;
         n  = 256'(d) << 32;
         sq = 256'(root_floor(n));
         if (b <= 0 && c >= 0) begin
            m = -bw * 65536 - sq;
            if (sq * sq != signed'(n)) m = m - 1;
         end else if (b <= 0 || c <= 0) begin
            m = -bw * 65536 + sq;
         end else begin
            return res;
         end
         if (m < 0) m = 0;
         q = 256'(m) / 256'(a);
         res.hit = 1'b1;
         res.contact_time = (q > 256'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
         return res;
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      mismatch_count++;
   endtask

   // send one word, waiting for acceptance; valid stays up for a following word
   task automatic send_pair(logic [62:0] p1, logic [62:0] p2, logic [62:0] v1,
                            logic [62:0] v2, logic [19:0] r1, logic [19:0] r2);
      while ($urandom_range(99) < idle_percent) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid         <= 1'b1;
      req.pos_first     <= p1;
      req.pos_second    <= p2;
      req.vel_first     <= v1;
      req.vel_second    <= v2;
      req.radius_first  <= r1;
      req.radius_second <= r2;
      expected_contacts.push_back(predict_contact(p1, p2, v1, v2, r1, r2));
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // drop valid after a burst of words
   task automatic end_burst();
      req.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [62:0] pack3(int x, int y, int z);
      return {21'(z), 21'(y), 21'(x)};
   endfunction

   function automatic logic [62:0] rand_vec();
      return 63'({$urandom, $urandom});
   endfunction

   // small components keep times inside range more often
   function automatic logic [62:0] near_vec(int span);
      return pack3($urandom_range(2*span) - span, $urandom_range(2*span) - span,
                   $urandom_range(2*span) - span);
   endfunction

   task automatic test_directed();
      logic [62:0] pmax, pmin;
      pmax = pack3(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF);
      pmin = pack3(-1048576, -1048576, -1048576);
      // zero relative speed
      send_pair(pack3(0, 0, 0), pack3(4096, 0, 0), pack3(1024, 0, 0), pack3(1024, 0, 0),
                20'd1024, 20'd1024);
      // head-on approach
      send_pair(pack3(0, 0, 0), pack3(10240, 0, 0), pack3(1024, 0, 0), pack3(0, 0, 0),
                20'd1024, 20'd1024);
      // moving apart, both roots negative
      send_pair(pack3(0, 0, 0), pack3(10240, 0, 0), pack3(-1024, 0, 0), pack3(0, 0, 0),
                20'd1024, 20'd1024);
      // negative discriminant, passing miss
      send_pair(pack3(0, 0, 0), pack3(10240, 8192, 0), pack3(1024, 0, 0), pack3(0, 0, 0),
                20'd1024, 20'd1024);
      // tangent contact ahead and behind
      send_pair(pack3(0, 0, 0), pack3(10240, 2048, 0), pack3(1024, 0, 0), pack3(0, 0, 0),
                20'd1024, 20'd1024);
      send_pair(pack3(0, 0, 0), pack3(-10240, 2048, 0), pack3(1024, 0, 0), pack3(0, 0, 0),
                20'd1024, 20'd1024);
      // already overlapping reports separation
      send_pair(pack3(0, 0, 0), pack3(512, 0, 0), pack3(0, 1024, 0), pack3(0, 0, 0),
                20'd1024, 20'd1024);
      // very slow approach saturates time
      send_pair(pmin, pmax, pack3(1, 1, 1), pack3(0, 0, 0), 20'd0, 20'd0);
      // extremes of fields
      send_pair(pmax, pmin, pmin, pmax, 20'hFFFFF, 20'hFFFFF);
      send_pair(pmin, pmax, pmax, pmin, 20'hFFFFF, 20'd0);
      send_pair('1, '0, '1, '0, 20'h80000, 20'h7FFFF);
      send_pair('0, '0, pmax, '0, 20'd0, 20'd0);
      send_pair('0, '0, '0, '0, 20'd0, 20'd0);
      end_burst();
   endtask

   task automatic test_random(int count, int pct);
      idle_percent = pct;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: send_pair(rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                         20'($urandom), 20'($urandom));
            default: send_pair(near_vec(20000), near_vec(20000), near_vec(3000),
                               near_vec(3000), 20'($urandom_range(8192)),
                               20'($urandom_range(8192)));
         endcase
      end
      end_burst();
   endtask

   task automatic wait_drained();
      while (expected_contacts.size() != 0) @(negedge clock);
   endtask

   // result ready with random stalls
   always @(negedge clock) begin
      rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= idle_percent);
   end

   // result checker
   always @(posedge clock) begin
      contact_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_contacts.size() == 0) begin
            report_mismatch("unexpected word", rsp.hit, 0);
         end else begin
            want = expected_contacts.pop_front();
            if (rsp.hit !== want.hit) report_mismatch("hit", rsp.hit, want.hit);
            if (rsp.contact_time !== want.contact_time)
               report_mismatch("contact_time", rsp.contact_time, want.contact_time);
         end
      end
   end

   // watchdog on cycles without progress
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset ||
          (expected_contacts.size() == 0 && !req.valid))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req.valid         = 1'b0;
      req.pos_first     = '0;
      req.pos_second    = '0;
      req.vel_first     = '0;
      req.vel_second    = '0;
      req.radius_first  = '0;
      req.radius_second = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(250, 17);
      wait_drained();
      test_random(150, 0);
      test_random(250, 17);
      wait_drained();
      repeat (120) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
